@@ rtl/twdt_pkg.sv @@
// Shared types and constants for the time-window duplicate filter.
// No dependencies; imported by the age unit, the top level and the testbench.
package twdt_pkg;

    // Field widths
    localparam int unsigned NODE_W  = 16;
    localparam int unsigned TAG_W   = 24;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SLOT_W  = 4;

    // Table depth default
    localparam int unsigned ENTRIES_DEF = 16;

    // Configuration port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [TIME_W-1:0] WINDOW_RST = 32'd5000;

    // Register index, taken from paddr bit 2
    localparam logic REG_WINDOW = 1'b0;

    // Command codes
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Input word
    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] node_id;
        logic [TAG_W-1:0]  seq_tag;
        logic [TIME_W-1:0] now_ms;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic              is_dup;
        logic [SLOT_W-1:0] slot_written;
    } out_word_t;

    // One stored table entry
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] seen_ms;
    } entry_t;

    // Flags from the shared age unit
    typedef struct packed {
        logic [TIME_W-1:0] age;
        logic              expired;
        logic              older;
    } age_res_t;

endpackage

@@ rtl/twdt_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing; used for the entry store of the filter.
module twdt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/twdt_age_unit.sv @@
// Shared age unit: one modulo-2^32 subtract and its compares.
// Depends on twdt_pkg; used once per entry by the scan sequencer.
module twdt_age_unit import twdt_pkg::*; (
    input  logic [TIME_W-1:0] now_ms,
    input  logic [TIME_W-1:0] seen_ms,
    input  logic [TIME_W-1:0] window_ms,
    input  logic [TIME_W-1:0] oldest_ms,
    output age_res_t          res
);

    logic [TIME_W-1:0] age;

    // Age wraps with the millisecond counter
    assign age = now_ms - seen_ms;

    assign res.age     = age;
    assign res.expired = (age > window_ms);
    assign res.older   = (age > oldest_ms);

endmodule

@@ rtl/time_window_dedup_table_core.sv @@
// Time-window duplicate filter: top level with scan sequencer and config port.
// Depends on twdt_pkg, twdt_ram and twdt_age_unit.
//
// A check word walks the table one entry at a time through a single age unit:
// each entry takes a RAM read state, then an evaluate state; after the last
// entry a write state stores the word and a done state hands the result on.
// A check ends early when a duplicate is found. A clear word goes straight to
// the done state. The block takes one word at a time; the result sits in an output
// register, so the next word is accepted while it waits. A word that finishes
// while an earlier result is still waiting holds until that result is taken.
// window_ms is written over the APB port at byte address 0 and should be
// changed only while idle.
module time_window_dedup_table_core import twdt_pkg::*; #(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   target_reg, target_next;
    logic               have_free_reg, have_free_next;
    logic               have_any_reg, have_any_next;
    logic [TIME_W-1:0]  oldest_reg, oldest_next;
    in_word_t           item_reg, item_next;
    out_word_t          res_reg, res_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic               m_valid_reg, m_valid_next;
    out_word_t          m_data_reg, m_data_next;
    logic [TIME_W-1:0]  window_reg;

    entry_t             rd_entry;
    entry_t             wr_entry;
    logic               wr_en;
    age_res_t           age_res;
    logic               key_match;
    logic [IDX_W+SLOT_W-1:0] target_ext;

    // Entry store
    twdt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (target_reg),
        .wr_data (wr_entry),
        .rd_addr (idx_reg),
        .rd_data (rd_entry)
    );

    // Shared age compare
    twdt_age_unit u_age (
        .now_ms    (item_reg.now_ms),
        .seen_ms   (rd_entry.seen_ms),
        .window_ms (window_reg),
        .oldest_ms (oldest_reg),
        .res       (age_res)
    );

    assign key_match = valid_reg[idx_reg] && (rd_entry.node == item_reg.node_id) &&
                       (rd_entry.tag == item_reg.seq_tag);

    assign wr_entry.node    = item_reg.node_id;
    assign wr_entry.tag     = item_reg.seq_tag;
    assign wr_entry.seen_ms = item_reg.now_ms;
    assign wr_en            = (state_reg == ST_WRITE);
    assign target_ext       = {{SLOT_W{1'b0}}, target_reg};

    // Sequencer next state
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        target_next    = target_reg;
        have_free_next = have_free_reg;
        have_any_next  = have_any_reg;
        oldest_next    = oldest_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        valid_next     = valid_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        // Result register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next      = s_data;
                    res_next       = '0;
                    idx_next       = '0;
                    target_next    = '0;
                    have_free_next = 1'b0;
                    have_any_next  = 1'b0;
                    oldest_next    = '0;
                    if (s_data.cmd == CMD_CLEAR) begin
                        valid_next = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (key_match && !age_res.expired) begin
                    // Seen within window: report and leave the table alone
                    res_next.is_dup = 1'b1;
                    state_next      = ST_DONE;
                end else begin
                    // First free or expired slot wins, else track the oldest
                    if (!have_free_reg) begin
                        if (!valid_reg[idx_reg] || age_res.expired) begin
                            target_next    = idx_reg;
                            have_free_next = 1'b1;
                        end else if (!have_any_reg || age_res.older) begin
                            target_next   = idx_reg;
                            oldest_next   = age_res.age;
                            have_any_next = 1'b1;
                        end
                    end
                    if (idx_reg == IDX_LAST) begin
                        state_next = ST_WRITE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_WRITE: begin
                valid_next[target_reg] = 1'b1;
                res_next.slot_written  = target_ext[SLOT_W-1:0];
                state_next             = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        target_reg    <= target_next;
        have_free_reg <= have_free_next;
        have_any_reg  <= have_any_next;
        oldest_reg    <= oldest_next;
        item_reg      <= item_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    // Window register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW) begin
            window_reg <= pwdata;
        end
    end

    assign prdata  = (paddr[2] == REG_WINDOW) ? window_reg : '0;
    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ tb/twdt_dedup_checker.sv @@
// Scoreboard for the time-window duplicate filter: tracks the table and window,
// predicts each result word and compares it. Depends on twdt_pkg.
module twdt_dedup_checker import twdt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_word_t           s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_word_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    output int unsigned        fail_count,
    output int unsigned        pending_words,
    output int unsigned        words_seen,
    output int unsigned        dups_seen,
    output int unsigned        clears_seen,
    output int unsigned        evictions_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the table and window
    entry_t            slot_key  [ENTRIES_DEF];
    logic              slot_live [ENTRIES_DEF];
    logic [TIME_W-1:0] window_q;
    out_word_t         verdict_q [$];
    out_word_t         want;

    function automatic void flag(string what, longint unsigned want_v, longint unsigned got_v);
        fail_count++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    endfunction

    // Duplicate lookup, then slot choice: first free or expired, else oldest
    function automatic out_word_t filter_word(in_word_t w);
        out_word_t         r;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest;
        int                victim;
        bit                aged_out;
        r = '0;
        words_seen++;
        if (w.cmd == CMD_CLEAR) begin
            for (int i = 0; i < ENTRIES_DEF; i++)
                slot_live[i] = 1'b0;
            clears_seen++;
            return r;
        end
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (slot_live[i] && slot_key[i].node == w.node_id && slot_key[i].tag == w.seq_tag) begin
                age = w.now_ms - slot_key[i].seen_ms;
                if (age <= window_q) begin
                    r.is_dup = 1'b1;
                    dups_seen++;
                    return r;
                end
            end
        end
        victim   = 0;
        oldest   = '0;
        aged_out = 1'b0;
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (!slot_live[i]) begin
                victim   = i;
                aged_out = 1'b0;
                break;
            end
            age = w.now_ms - slot_key[i].seen_ms;
            if (age > window_q) begin
                victim   = i;
                aged_out = 1'b0;
                break;
            end
            if (i == 0 || age > oldest) begin
                oldest   = age;
                victim   = i;
                aged_out = 1'b1;
            end
        end
        if (aged_out)
            evictions_seen++;
        slot_live[victim]        = 1'b1;
        slot_key[victim].node    = w.node_id;
        slot_key[victim].tag     = w.seq_tag;
        slot_key[victim].seen_ms = w.now_ms;
        r.slot_written = SLOT_W'(victim);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES_DEF; i++)
                slot_live[i] = 1'b0;
            window_q       = WINDOW_RST;
            verdict_q.delete();
            fail_count     = 0;
            pending_words  = 0;
            words_seen     = 0;
            dups_seen      = 0;
            clears_seen    = 0;
            evictions_seen = 0;
        end else begin
            // Register access; only the window register exists
            if (psel && penable && pready && paddr[2] == REG_WINDOW) begin
                if (pwrite)
                    window_q = pwdata;
                else if (prdata !== window_q)
                    flag("window_ms readback", window_q, prdata);
            end
            // Input word accepted
            if (s_valid && s_ready)
                verdict_q.push_back(filter_word(s_data));
            // Result word accepted
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result word with none pending, is_dup %0d slot_written %0d",
                             $time, m_data.is_dup, m_data.slot_written);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_data.is_dup !== want.is_dup)
                        flag("is_dup", want.is_dup, m_data.is_dup);
                    if (m_data.slot_written !== want.slot_written)
                        flag("slot_written", want.slot_written, m_data.slot_written);
                end
            end
            pending_words = verdict_q.size();
        end
    end

endmodule

@@ tb/tb_time_window_dedup_table_core.sv @@
// Testbench top for time_window_dedup_table_core: clock, reset, stimulus and verdict.
// Depends on twdt_pkg, the core RTL and twdt_dedup_checker.
module tb_time_window_dedup_table_core import twdt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR  = {~REG_WINDOW, 2'b00};
    localparam int unsigned        PER_PHASE   = 200;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_word_t           s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_word_t          m_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int unsigned fail_count, pending_words;
    int unsigned words_seen, dups_seen, clears_seen, evictions_seen;

    // Stimulus state
    int unsigned       tx_idle_pct = 0;
    int unsigned       rx_idle_pct = 0;
    logic [TIME_W-1:0] window_now = WINDOW_RST;
    logic [TIME_W-1:0] clock_ms;
    logic [NODE_W-1:0] node_pool [6];
    logic [TAG_W-1:0]  tag_pool  [4];

    always #5 aclk = ~aclk;

    time_window_dedup_table_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    twdt_dedup_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending_words  (pending_words),
        .words_seen     (words_seen),
        .dups_seen      (dups_seen),
        .clears_seen    (clears_seen),
        .evictions_seen (evictions_seen)
    );

    // Receiver backpressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic in_word_t key_word(logic cmd, logic [NODE_W-1:0] node,
                                          logic [TAG_W-1:0] tag, logic [TIME_W-1:0] now);
        in_word_t w;
        w.cmd     = cmd;
        w.node_id = node;
        w.seq_tag = tag;
        w.now_ms  = now;
        return w;
    endfunction

    // Mostly pooled keys with a moving clock; some noise keys, jumps and clears
    function automatic in_word_t random_word();
        int unsigned roll;
        int unsigned step_lim;
        roll     = $urandom_range(0, 99);
        step_lim = (window_now > 1000) ? 2000 : 2 * window_now + 2;
        if (roll < 45)
            clock_ms += $urandom_range(0, 3);
        else if (roll < 92)
            clock_ms += $urandom_range(0, step_lim);
        else
            clock_ms = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return key_word(CMD_CLEAR, NODE_W'($urandom()), TAG_W'($urandom()), clock_ms);
        if (roll < 12)
            return key_word(CMD_CHECK, NODE_W'($urandom()), TAG_W'($urandom()), clock_ms);
        return key_word(CMD_CHECK, node_pool[$urandom_range(0, 5)],
                        tag_pool[$urandom_range(0, 3)], clock_ms);
    endfunction

    task automatic send_word(input in_word_t w);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Block is idle once every result word is back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_window(input logic [TIME_W-1:0] value);
        wait_drained();
        apb_access(1'b1, WINDOW_ADDR, value);
        apb_access(1'b0, WINDOW_ADDR, '0);
        window_now = value;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: key extremes, window edge, expiry, clear
        send_word(key_word(CMD_CHECK, '0, '0, '0));
        send_word(key_word(CMD_CHECK, '0, '0, '0));
        send_word(key_word(CMD_CHECK, '1, '1, '1));
        send_word(key_word(CMD_CHECK, '1, '1, 32'd4999));  // age equals window across wrap
        send_word(key_word(CMD_CHECK, '0, '0, 32'd5001));  // one past window
        send_word(key_word(CMD_CLEAR, '1, '1, $urandom()));
        send_word(key_word(CMD_CHECK, '1, '1, 32'd4999));

        // Unused register address must not touch the window
        wait_drained();
        apb_access(1'b1, SPARE_ADDR, 32'd7);
        apb_access(1'b0, WINDOW_ADDR, '0);

        // Zero window: only an age of zero is a repeat
        set_window('0);
        send_word(key_word(CMD_CHECK, 16'h1234, 24'h000055, 32'd100));
        send_word(key_word(CMD_CHECK, 16'h1234, 24'h000055, 32'd100));
        send_word(key_word(CMD_CHECK, 16'h1234, 24'h000055, 32'd101));

        // Full-scale window: fill the table, then evict on an all-equal age tie
        set_window('1);
        send_word(key_word(CMD_CLEAR, '0, '0, '0));
        for (int i = 0; i < ENTRIES_DEF; i++)
            send_word(key_word(CMD_CHECK, NODE_W'(i + 256), TAG_W'(~i), 32'h8000_0000));
        send_word(key_word(CMD_CHECK, 16'hBEEF, 24'hC0FFEE, 32'h8000_0000));

        // Random phases, each with its own window and idling mix
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    set_window($urandom_range(20, 300));
                    tx_idle_pct = 25;
                    rx_idle_pct = 88;
                    clock_ms    = $urandom();
                end
                1: begin
                    set_window(32'd1);
                    tx_idle_pct = 88;
                    rx_idle_pct = 25;
                    clock_ms    = 32'hFFFF_FF00;
                end
                default: begin
                    set_window('1);
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    clock_ms    = $urandom();
                end
            endcase
            for (int i = 0; i < 6; i++)
                node_pool[i] = NODE_W'($urandom());
            for (int i = 0; i < 4; i++)
                tag_pool[i] = TAG_W'($urandom());
            for (int n = 0; n < PER_PHASE; n++)
                send_word(random_word());
        end

        // Drain and let any stray word show up
        wait_drained();
        repeat (40) @(posedge aclk);
        $display("Checked %0d words: %0d duplicates, %0d clears, %0d oldest-slot evictions.",
                 words_seen, dups_seen, clears_seen, evictions_seen);
        $display("Windows 0, 1, reset value, small random and full scale; stalls on both sides.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d result words outstanding", pending_words);
        $display("== FAIL ==");
        $finish;
    end

endmodule
